// ----- rtl/core/elder_ray_index_ema_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the elder ray index core
// Clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ELDER_RAY_INDEX_EMA_ASSERT_SVH
`define ELDER_RAY_INDEX_EMA_ASSERT_SVH

// same-cycle implication
`define ERI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ERI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/eri_pkg.sv -----
// ----------------------------------------------------------------------------
// eri_pkg
// Types and fixed constants shared by the elder ray index core.
// ----------------------------------------------------------------------------
package eri_pkg;

    localparam int AVG_EXTRA    = 16;
    localparam int COUNT_W      = 16;
    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 11;
    localparam int PERIOD_CFG_W = 11;
    localparam int UNSTABLE_W   = 8;
    localparam int K_W          = 32;
    localparam int K_SHIFT      = 34;

    localparam logic [COUNT_W-1:0]      COUNT_MAX      = '1;
    localparam logic [PERIOD_CFG_W-1:0] RESET_PERIOD   = 11'd30;
    localparam logic [UNSTABLE_W-1:0]   RESET_UNSTABLE = 8'd0;
    localparam logic [63:0]             LO_ROUND       = 64'h0000_0000_8000_0000;

    localparam logic [CFG_INDEX_W-1:0] REG_PERIOD   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNSTABLE = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KDIV,
        ST_EVAL,
        ST_SDIV,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_APPLY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- rtl/core/eri_div.sv -----
// ----------------------------------------------------------------------------
// eri_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eri_div #(
    parameter int DVD_W = 59,
    parameter int DVS_W = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [DVS_W-1:0]    divisor,
    output eri_pkg::div_stat_t  status,
    output logic [DVD_W-1:0]    quotient,
    output logic [DVS_W-1:0]    remainder
);
    import eri_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quot_reg, quot_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, quot_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DVD_W-2:0], fits};
            rem_next  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quot_reg;
    assign remainder   = rem_reg;

endmodule

// ----- rtl/core/elder_ray_index_ema.sv -----
// ----------------------------------------------------------------------------
// elder_ray_index_ema
// Elder ray index: bull and bear power against an EMA of close.
//
//   channel  direction  handshake                payload
//   s_axis   in         s_axis_tvalid/tready     tdata: high, low, close
//                                                tuser: series_start
//   m_axis   out        m_axis_tvalid/tready     tdata: bull, bear, bar_index
//   cfg      in         cfg_valid/cfg_ready      cfg_index, cfg_data
//
// An EMA bar passes eval, multiply low, multiply high, apply and emit before
// the core takes the next bar; the shared 32x32 multiplier runs twice per bar
// (low and high half of the difference). The seeding bar also runs the serial
// divider for its average, and a series start with period above 1 runs it for k.
// A result waits in the output register; a stalled output holds the core
// in its last step only when a new result must be loaded.
// Reset clears control state; cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "elder_ray_index_ema_assert.svh"

module elder_ray_index_ema #(
    parameter int PRICE_BITS = 32,
    parameter int MAX_PERIOD = 1024,
    localparam int S_TDATA_W = ((3 * PRICE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * (PRICE_BITS + 1) + eri_pkg::COUNT_W + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [S_TDATA_W-1:0]             s_axis_tdata,  // high_price, low_price, close_price
    input  logic                             s_axis_tuser,  // series_start
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [M_TDATA_W-1:0]             m_axis_tdata,  // bull_power, bear_power, bar_index
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [eri_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [eri_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import eri_pkg::*;

    localparam int AVG_W    = PRICE_BITS + AVG_EXTRA;
    localparam int RES_W    = PRICE_BITS + 1;
    localparam int PERIOD_W = $clog2(MAX_PERIOD + 1);
    localparam int DVS_W    = $clog2(MAX_PERIOD + 2);
    localparam int SUM_W    = PRICE_BITS + $clog2(MAX_PERIOD) + 1;
    localparam int DVD_W    = (SUM_W + AVG_EXTRA > K_SHIFT + 1) ? SUM_W + AVG_EXTRA
                                                                : K_SHIFT + 1;
    localparam int WARM_W   = ((PERIOD_W > UNSTABLE_W) ? PERIOD_W : UNSTABLE_W) + 1;
    localparam int CMP_W    = (WARM_W > COUNT_W) ? WARM_W : COUNT_W;
    localparam int HI_W     = (AVG_W > 32) ? AVG_W - 32 : 1;
    localparam int MAGX_W   = 32 + HI_W;
    localparam int MUL_A_W  = (HI_W > 32) ? HI_W : 32;
    localparam int PROD_W   = MUL_A_W + K_W;
    localparam int DELTA_W  = HI_W + 33;
    localparam int UPD_W    = ((AVG_W > DELTA_W) ? AVG_W : DELTA_W) + 1;

    state_t state_reg, state_next;

    logic [PERIOD_CFG_W-1:0] period_reg, period_next;
    logic [UNSTABLE_W-1:0]   unstable_reg, unstable_next;
    logic                    fresh_reg, fresh_next;
    logic                    out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]      bar_counter_reg, bar_counter_next;

    logic [PERIOD_W-1:0]     run_period_reg, run_period_next;
    logic [UNSTABLE_W-1:0]   run_unstable_reg, run_unstable_next;
    logic [K_W-1:0]          smoothing_reg, smoothing_next;
    logic [SUM_W-1:0]        seed_sum_reg, seed_sum_next;
    logic [AVG_W-1:0]        average_reg, average_next;
    logic [PRICE_BITS-1:0]   high_reg, high_next;
    logic [PRICE_BITS-1:0]   low_reg, low_next;
    logic [PRICE_BITS-1:0]   close_reg, close_next;
    logic                    sum_neg_reg, sum_neg_next;
    logic                    up_reg, up_next;
    logic [MAGX_W-1:0]       mag_reg, mag_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [31:0]             round_reg, round_next;
    logic [RES_W-1:0]        bull_reg, bull_next;
    logic [RES_W-1:0]        bear_reg, bear_next;
    logic [COUNT_W-1:0]      index_reg, index_next;

    // FSM outputs
    logic in_accept;
    logic restart;
    logic div_start;
    logic div_sel_k;
    logic emit_go;

    // datapath
    logic [PERIOD_W-1:0]     p_clamped;
    logic [DVD_W-1:0]        div_dividend;
    logic [DVS_W-1:0]        div_divisor;
    div_stat_t               div_stat;
    logic [DVD_W-1:0]        div_quot;
    logic [DVS_W-1:0]        div_rem;
    logic [CMP_W-1:0]        idx_ext;
    logic [CMP_W-1:0]        pm1_ext;
    logic [CMP_W-1:0]        warm_ext;
    logic                    is_p1;
    logic [SUM_W-1:0]        sum_add;
    logic [SUM_W-1:0]        sum_mag;
    logic [AVG_W-1:0]        target;
    logic [AVG_W:0]          diff_tu;
    logic [AVG_W:0]          diff_ut;
    logic                    up_now;
    logic [MUL_A_W-1:0]      mul_a;
    logic [PROD_W-1:0]       mul_prod;
    logic [63:0]             lo_sum;
    logic [DELTA_W-1:0]      delta;
    logic [UPD_W-1:0]        avg_upd;
    logic [32:0]             k_round;
    logic                    seed_up;
    logic [DVD_W-1:0]        seed_q;
    logic [DVD_W-1:0]        seed_s;
    logic [AVG_W:0]          avg_rnd;
    logic [RES_W-1:0]        avg_r;

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if ((s_axis_tuser || fresh_reg) && (p_clamped != PERIOD_W'(1)))
                        state_next = ST_KDIV;
                    else
                        state_next = ST_EVAL;
                end
            end
            ST_KDIV:
            begin
                if (div_stat.done)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (is_p1 || (idx_ext < pm1_ext))
                    state_next = ST_EMIT;
                else if (idx_ext == pm1_ext)
                    state_next = ST_SDIV;
                else
                    state_next = ST_MUL_LO;
            end
            ST_SDIV:
            begin
                if (div_stat.done)
                    state_next = ST_EMIT;
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit_go)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // FSM outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        in_accept     = 1'b0;
        restart       = 1'b0;
        div_start     = 1'b0;
        div_sel_k     = 1'b0;
        emit_go       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                in_accept     = s_axis_tvalid;
                restart       = s_axis_tvalid && (s_axis_tuser || fresh_reg);
                div_sel_k     = 1'b1;
                div_start     = restart && (p_clamped != PERIOD_W'(1));
            end
            ST_EVAL:
            begin
                div_start = !is_p1 && (idx_ext == pm1_ext);
            end
            ST_EMIT:
            begin
                emit_go = !out_valid_reg || m_axis_tready || (idx_ext < warm_ext);
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------------
    always_comb
    begin
        if (period_reg == '0)
            p_clamped = PERIOD_W'(1);
        else if (32'(period_reg) > 32'(MAX_PERIOD))
            p_clamped = PERIOD_W'(MAX_PERIOD);
        else
            p_clamped = PERIOD_W'(period_reg);
    end

    always_comb
    begin
        is_p1    = (run_period_reg == PERIOD_W'(1));
        idx_ext  = CMP_W'(bar_counter_reg);
        pm1_ext  = CMP_W'(run_period_reg) - CMP_W'(1);
        warm_ext = pm1_ext + CMP_W'(run_unstable_reg);

        sum_add  = seed_sum_reg
                 + {{(SUM_W - PRICE_BITS){close_reg[PRICE_BITS-1]}}, close_reg};
        sum_mag  = sum_add[SUM_W-1] ? (SUM_W'(0) - sum_add) : sum_add;

        target   = {close_reg, {AVG_EXTRA{1'b0}}};
        diff_tu  = {target[AVG_W-1], target} - {average_reg[AVG_W-1], average_reg};
        diff_ut  = {average_reg[AVG_W-1], average_reg} - {target[AVG_W-1], target};
        up_now   = !diff_tu[AVG_W];

        if (div_sel_k)
        begin
            div_dividend = DVD_W'({1'b1, {K_SHIFT{1'b0}}});
            div_divisor  = DVS_W'(p_clamped) + DVS_W'(1);
        end
        else
        begin
            div_dividend = DVD_W'({sum_mag, {AVG_EXTRA{1'b0}}});
            div_divisor  = DVS_W'(run_period_reg);
        end

        if (state_reg == ST_MUL_LO)
            mul_a = MUL_A_W'(mag_reg[31:0]);
        else
            mul_a = MUL_A_W'(mag_reg[MAGX_W-1:32]);
        mul_prod = PROD_W'(mul_a) * PROD_W'(smoothing_reg);

        lo_sum   = prod_reg[63:0] + LO_ROUND;
        delta    = DELTA_W'(prod_reg[HI_W+31:0]) + DELTA_W'(round_reg);
        if (up_reg)
            avg_upd = UPD_W'($signed(average_reg)) + UPD_W'(delta);
        else
            avg_upd = UPD_W'($signed(average_reg)) - UPD_W'(delta);

        k_round  = div_quot[32:0] + 33'd1;

        seed_up  = ({1'b0, div_rem, 1'b0} >= (DVS_W + 2)'(run_period_reg));
        seed_q   = div_quot + DVD_W'(seed_up);
        seed_s   = sum_neg_reg ? (DVD_W'(0) - seed_q) : seed_q;

        avg_rnd  = {average_reg[AVG_W-1], average_reg}
                 + (AVG_W + 1)'({1'b1, {(AVG_EXTRA - 1){1'b0}}});
        avg_r    = avg_rnd[AVG_W:AVG_EXTRA];
    end

    always_comb
    begin
        period_next       = period_reg;
        unstable_next     = unstable_reg;
        fresh_next        = fresh_reg;
        bar_counter_next  = bar_counter_reg;
        run_period_next   = run_period_reg;
        run_unstable_next = run_unstable_reg;
        smoothing_next    = smoothing_reg;
        seed_sum_next     = seed_sum_reg;
        average_next      = average_reg;
        high_next         = high_reg;
        low_next          = low_reg;
        close_next        = close_reg;
        sum_neg_next      = sum_neg_reg;
        up_next           = up_reg;
        mag_next          = mag_reg;
        prod_next         = prod_reg;
        round_next        = round_reg;
        bull_next         = bull_reg;
        bear_next         = bear_reg;
        index_next        = index_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_PERIOD:   period_next   = cfg_data[PERIOD_CFG_W-1:0];
                REG_UNSTABLE: unstable_next = cfg_data[UNSTABLE_W-1:0];
                default:      period_next   = period_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    high_next  = s_axis_tdata[PRICE_BITS-1:0];
                    low_next   = s_axis_tdata[2*PRICE_BITS-1:PRICE_BITS];
                    close_next = s_axis_tdata[3*PRICE_BITS-1:2*PRICE_BITS];
                end
                if (restart)
                begin
                    run_period_next   = p_clamped;
                    run_unstable_next = unstable_reg;
                    smoothing_next    = '0;
                    bar_counter_next  = '0;
                    seed_sum_next     = '0;
                    average_next      = '0;
                    fresh_next        = 1'b0;
                end
            end
            ST_KDIV:
            begin
                if (div_stat.done)
                    smoothing_next = k_round[32:1];
            end
            ST_EVAL:
            begin
                if (is_p1)
                    average_next = target;
                else if (idx_ext <= pm1_ext)
                begin
                    seed_sum_next = sum_add;
                    sum_neg_next  = sum_add[SUM_W-1];
                end
                else
                begin
                    up_next  = up_now;
                    mag_next = up_now ? MAGX_W'(diff_tu[AVG_W-1:0])
                                      : MAGX_W'(diff_ut[AVG_W-1:0]);
                end
            end
            ST_SDIV:
            begin
                if (div_stat.done)
                    average_next = seed_s[AVG_W-1:0];
            end
            ST_MUL_LO:
            begin
                prod_next = mul_prod;
            end
            ST_MUL_HI:
            begin
                round_next = lo_sum[63:32];
                prod_next  = mul_prod;
            end
            ST_APPLY:
            begin
                average_next = avg_upd[AVG_W-1:0];
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    if (bar_counter_reg != COUNT_MAX)
                        bar_counter_next = bar_counter_reg + COUNT_W'(1);
                    if (idx_ext >= warm_ext)
                    begin
                        bull_next      = {high_reg[PRICE_BITS-1], high_reg} - avg_r;
                        bear_next      = {low_reg[PRICE_BITS-1], low_reg} - avg_r;
                        index_next     = bar_counter_reg;
                        out_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_axis_tready;
            end
        endcase
    end

    eri_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            period_reg      <= RESET_PERIOD;
            unstable_reg    <= RESET_UNSTABLE;
            fresh_reg       <= 1'b1;
            out_valid_reg   <= 1'b0;
            bar_counter_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            period_reg      <= period_next;
            unstable_reg    <= unstable_next;
            fresh_reg       <= fresh_next;
            out_valid_reg   <= out_valid_next;
            bar_counter_reg <= bar_counter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_period_reg   <= run_period_next;
        run_unstable_reg <= run_unstable_next;
        smoothing_reg    <= smoothing_next;
        seed_sum_reg     <= seed_sum_next;
        average_reg      <= average_next;
        high_reg         <= high_next;
        low_reg          <= low_next;
        close_reg        <= close_next;
        sum_neg_reg      <= sum_neg_next;
        up_reg           <= up_next;
        mag_reg          <= mag_next;
        prod_reg         <= prod_next;
        round_reg        <= round_next;
        bull_reg         <= bull_next;
        bear_reg         <= bear_next;
        index_reg        <= index_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({index_reg, bear_reg, bull_reg});

    `ERI_ASSERT_IMPLY(a_div_done_state, div_stat.done,
        (state_reg == ST_KDIV) || (state_reg == ST_SDIV), "divider done outside a divide step")
    `ERI_ASSERT_IMPLY(a_div_busy_state, div_stat.busy,
        (state_reg == ST_KDIV) || (state_reg == ST_SDIV), "divider busy outside a divide step")
    `ERI_ASSERT_IMPLY(a_mul_period, state_reg == ST_MUL_LO,
        run_period_reg > PERIOD_W'(1), "EMA multiply with period below two")
    `ERI_ASSERT_NEXT(a_count_step, emit_go && (bar_counter_reg != COUNT_MAX),
        bar_counter_reg == $past(bar_counter_reg) + COUNT_W'(1), "bar counter missed a step")
    `ERI_ASSERT_NEXT(a_ema_up, (state_reg == ST_APPLY) && up_reg,
        $signed(average_reg) >= $signed($past(average_reg)), "EMA moved away from close")

endmodule

// ----- bench/eri_power_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eri_power_checker
// Watches the bar, result and register channels of the elder ray index core,
// tracks its EMA state bit for bit and compares every result field by field.
// ----------------------------------------------------------------------------
module eri_power_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [95:0]                      s_axis_tdata,  // high_price, low_price, close_price
    input  logic                             s_axis_tuser,  // series_start
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [87:0]                      m_axis_tdata,  // bull_power, bear_power, bar_index
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [eri_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [eri_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               error_count,
    output int                               pending_count
);

    localparam int          PERIOD_LIMIT = 1024;
    localparam int          REPORT_LIMIT = 10;
    localparam logic [63:0] SIGN_MASK    = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [32:0] bull;
        logic [32:0] bear;
        logic [15:0] idx;
    } power_t;

    power_t      expected_powers[$];

    logic [10:0] reg_period;
    logic [7:0]  reg_unstable;
    logic [15:0] bar_count;
    logic [63:0] close_sum;
    logic [63:0] ema_q;
    logic [31:0] k_q;
    int unsigned live_period;
    int unsigned live_unstable;
    bit          new_run;
    int          fails = 0;

    function automatic logic [63:0] seed_average(input logic [63:0] sum, input int unsigned p);
        logic        neg;
        logic [63:0] pw, mag, q, r, d, rem, res;
        pw  = 64'(p);
        neg = sum[63];
        mag = neg ? 64'd0 - sum : sum;
        q   = mag / pw;
        r   = mag % pw;
        d   = (r << eri_pkg::AVG_EXTRA) / pw;
        rem = (r << eri_pkg::AVG_EXTRA) % pw;
        if ((rem << 1) >= pw)
            d = d + 64'd1;
        res = (q << eri_pkg::AVG_EXTRA) + d;
        return neg ? 64'd0 - res : res;
    endfunction

    function automatic logic [63:0] ema_next(input logic [63:0] avg, input logic [63:0] target,
                                             input logic [31:0] k);
        logic        up;
        logic [63:0] mag, kk, delta;
        up    = $signed(target) >= $signed(avg);
        mag   = up ? target - avg : avg - target;
        kk    = {32'd0, k};
        delta = (mag >> 32) * kk + (({32'd0, mag[31:0]} * kk + eri_pkg::LO_ROUND) >> 32);
        return up ? avg + delta : avg - delta;
    endfunction

    function automatic logic [63:0] to_price_grid(input logic [63:0] avg);
        logic [63:0] biased;
        biased = ((avg ^ SIGN_MASK) + (64'd1 << (eri_pkg::AVG_EXTRA - 1))) >> eri_pkg::AVG_EXTRA;
        return biased - (SIGN_MASK >> eri_pkg::AVG_EXTRA);
    endfunction

    task automatic open_series();
        int unsigned p;
        p = reg_period;
        if (p < 1)
            p = 1;
        if (p > PERIOD_LIMIT)
            p = PERIOD_LIMIT;
        live_period   = p;
        live_unstable = reg_unstable;
        if (p >= 2)
            k_q = 32'((((64'd1 << eri_pkg::K_SHIFT) / (64'(p) + 64'd1)) + 64'd1) >> 1);
        else
            k_q = 32'd0;
        bar_count = '0;
        close_sum = '0;
        ema_q     = '0;
    endtask

    task automatic absorb_bar(input logic [31:0] hi_p, input logic [31:0] lo_p,
                              input logic [31:0] cl_p, input logic st);
        logic [63:0] hi, lo, cl, avg_r;
        int unsigned idx, warm;
        power_t      want;
        hi = {{32{hi_p[31]}}, hi_p};
        lo = {{32{lo_p[31]}}, lo_p};
        cl = {{32{cl_p[31]}}, cl_p};
        if (st || new_run)
        begin
            open_series();
            new_run = 1'b0;
        end
        idx = bar_count;
        if (live_period == 1)
            ema_q = cl << eri_pkg::AVG_EXTRA;
        else if (idx < live_period - 1)
            close_sum = close_sum + cl;
        else if (idx == live_period - 1)
        begin
            close_sum = close_sum + cl;
            ema_q     = seed_average(close_sum, live_period);
        end
        else
            ema_q = ema_next(ema_q, cl << eri_pkg::AVG_EXTRA, k_q);
        if (bar_count != eri_pkg::COUNT_MAX)
            bar_count = bar_count + 16'd1;
        warm = live_period - 1 + live_unstable;
        if (idx >= warm)
        begin
            avg_r     = (live_period == 1) ? cl : to_price_grid(ema_q);
            want.bull = 33'(hi - avg_r);
            want.bear = 33'(lo - avg_r);
            want.idx  = 16'(idx);
            expected_powers.push_back(want);
        end
    endtask

    task automatic report_fault(input string what, input logic [63:0] want,
                                input logic [63:0] got);
        fails = fails + 1;
        if (fails <= REPORT_LIMIT)
            $display("ERROR: %s expected %h got %h at %0t", what, want, got, $time);
    endtask

    task automatic check_power(input logic [87:0] data);
        power_t got, want;
        got.bull = data[32:0];
        got.bear = data[65:33];
        got.idx  = data[81:66];
        if (expected_powers.size() == 0)
            report_fault("unexpected result", 64'd0, {40'd0, got.idx, 8'd0});
        else
        begin
            want = expected_powers.pop_front();
            if (got.bull !== want.bull)
                report_fault("bull_power", 64'(want.bull), 64'(got.bull));
            if (got.bear !== want.bear)
                report_fault("bear_power", 64'(want.bear), 64'(got.bear));
            if (got.idx !== want.idx)
                report_fault("bar_index", 64'(want.idx), 64'(got.idx));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            reg_period   = eri_pkg::RESET_PERIOD;
            reg_unstable = eri_pkg::RESET_UNSTABLE;
            open_series();
            new_run = 1'b1;
            expected_powers.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == eri_pkg::REG_PERIOD)
                    reg_period = cfg_data;
                else if (cfg_index == eri_pkg::REG_UNSTABLE)
                    reg_unstable = cfg_data[7:0];
            end
            if (m_axis_tvalid && m_axis_tready)
                check_power(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                absorb_bar(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64],
                           s_axis_tuser);
        end
        error_count   <= fails;
        pending_count <= expected_powers.size();
    end

endmodule

// ----- bench/tb_elder_ray_index_ema.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_elder_ray_index_ema
// Drives price bars and register writes into the elder ray index core under
// random flow control and reports the verdict from the power checker.
// ----------------------------------------------------------------------------
module tb_elder_ray_index_ema;

    localparam int          MAX_PERIOD   = 1024;
    localparam int          CLEAR_CYCLES = 200;
    localparam int          TIMEOUT_NS   = 50_000_000;
    localparam logic [7:0]  REG_SPARE    = 8'd2;
    localparam logic [7:0]  REG_LAST     = 8'hFF;
    localparam logic [31:0] PRICE_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] PRICE_MIN    = 32'h8000_0000;

    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [95:0]                      s_axis_tdata  = '0;  // high_price, low_price, close_price
    logic                             s_axis_tuser  = 1'b0;  // series_start
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [87:0]                      m_axis_tdata;  // bull_power, bear_power, bar_index
    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic [eri_pkg::CFG_INDEX_W-1:0]  cfg_index     = '0;
    logic [eri_pkg::CFG_DATA_W-1:0]   cfg_data      = '0;

    int error_count;
    int pending_count;
    int send_gap_pct = 0;
    int take_gap_pct = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    elder_ray_index_ema u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    eri_power_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= take_gap_pct);
    end

    task automatic push_bar(input logic [31:0] hi, input logic [31:0] lo,
                            input logic [31:0] cl, input logic st);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cl, lo, hi};
        s_axis_tuser  <= st;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold the bar channel until every expected result is out and the core is quiet
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_count != 0);
        repeat (CLEAR_CYCLES) @(posedge clk);
    endtask

    function automatic int unsigned series_len(input int unsigned warm);
        if ($urandom_range(9) < 8)
            return warm + 1 + $urandom_range(40);
        return $urandom_range(warm + 3, 1);
    endfunction

    function automatic logic [31:0] price_near(input logic [31:0] level);
        case ($urandom_range(9))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(3))
                    0: return PRICE_MAX;
                    1: return PRICE_MIN;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return level + $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
        endcase
    endfunction

    task automatic run_phase(input logic [10:0] per_w, input logic [10:0] unst_w,
                             input int n_bars, input bit one_run);
        int unsigned eff_p, warm, left;
        logic [31:0] level;
        bit          st;
        drain_results();
        write_reg(eri_pkg::REG_PERIOD, per_w);
        write_reg(eri_pkg::REG_UNSTABLE, unst_w);
        eff_p = (per_w == 0) ? 1 : ((per_w > MAX_PERIOD) ? MAX_PERIOD : per_w);
        warm  = eff_p - 1 + unst_w[7:0];
        level = $urandom;
        left  = one_run ? n_bars : series_len(warm);
        st    = one_run || ($urandom_range(9) < 7);
        for (int i = 0; i < n_bars; i++)
        begin
            if (left == 0)
            begin
                st    = 1'b1;
                left  = series_len(warm);
                level = $urandom;
            end
            left  = left - 1;
            level = level + $urandom_range(4096) - 32'd2048;
            push_bar(price_near(level), price_near(level), price_near(level), st);
            st = 1'b0;
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 30;
        take_gap_pct <= 57;
        write_reg(REG_SPARE, 11'h7FF);
        write_reg(REG_LAST, 11'h000);
        write_reg(eri_pkg::REG_PERIOD, 11'd1);
        push_bar(PRICE_MAX, PRICE_MIN, PRICE_MIN, 1'b0);
        push_bar(PRICE_MIN, PRICE_MAX, PRICE_MAX, 1'b0);
        push_bar(32'hFFFF_FFFF, 32'h0, 32'h1, 1'b1);
        push_bar(32'h0, 32'hFFFF_FFFF, PRICE_MAX, 1'b0);
        drain_results();

        write_reg(eri_pkg::REG_PERIOD, 11'd2);
        push_bar(32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);
        push_bar(PRICE_MAX, PRICE_MIN, 32'h0, 1'b0);
        push_bar(PRICE_MAX, PRICE_MIN, PRICE_MAX, 1'b1);
        push_bar(PRICE_MIN, PRICE_MAX, PRICE_MAX, 1'b0);
        push_bar(PRICE_MAX, PRICE_MIN, PRICE_MIN, 1'b0);
        push_bar(PRICE_MIN, PRICE_MAX, PRICE_MIN, 1'b0);
        push_bar(32'h0001_0000, 32'hFFFF_0000, PRICE_MAX, 1'b0);
        drain_results();

        // new settings must wait for the next series start
        write_reg(eri_pkg::REG_PERIOD, 11'd3);
        write_reg(eri_pkg::REG_UNSTABLE, 11'd1);
        push_bar(32'h0002_0000, 32'h0001_0000, 32'h0001_8000, 1'b0);
        push_bar(32'h0003_0000, 32'h0000_8000, 32'h0002_0000, 1'b0);
        push_bar(32'hFFFF_8000, 32'hFFFE_0000, 32'hFFFF_0000, 1'b0);
        push_bar(32'h0004_0000, 32'h0001_0000, 32'h0003_0000, 1'b1);
        push_bar(32'h0005_0000, 32'h0002_0000, 32'h0004_0000, 1'b0);
        push_bar(32'h0006_0000, 32'h0003_0000, 32'h0005_0000, 1'b0);
        push_bar(32'h0007_0000, 32'h0004_0000, 32'h0006_0000, 1'b0);
        push_bar(32'h0008_0000, 32'h0005_0000, 32'h0007_0000, 1'b0);

        run_phase(11'd5, 11'd0, 80, 1'b0);
        run_phase(11'd0, 11'd6, 50, 1'b0);
        run_phase(11'd16, 11'd2, 60, 1'b0);

        drain_results();
        send_gap_pct = 57;
        take_gap_pct <= 30;
        run_phase(11'd3, 11'h7FF, 265, 1'b1);
        run_phase(11'd30, 11'd1, 40, 1'b0);

        drain_results();
        send_gap_pct = 0;
        take_gap_pct <= 0;
        run_phase(11'h7FF, 11'd0, 15, 1'b1);
        run_phase(11'd4, 11'd3, 30, 1'b0);

        drain_results();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/eri_pkg.sv
rtl/core/eri_div.sv
rtl/core/elder_ray_index_ema.sv
bench/eri_power_checker.sv
bench/tb_elder_ray_index_ema.sv
